// File: rtl/ipv4_rx_header_check_unit_assert.svh
// Assertion macros for the IPv4 receive header check unit.
// Included by the RTL files that carry concurrent assertions; needs no other file.
`ifndef IPV4_RX_HEADER_CHECK_UNIT_ASSERT_SVH
`define IPV4_RX_HEADER_CHECK_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define IPV4RX_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define IPV4RX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ipv4rx_pkg.sv
// Shared types and status codes for the IPv4 receive header check unit.
// Has no dependencies; every other RTL module file imports it.
`timescale 1ns / 1ps

package ipv4rx_pkg;

   localparam int unsigned TDATA_IN_W  = 8;
   localparam int unsigned TDATA_OUT_W = 56;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_TOO_SHORT    = 3'd1,
      ST_BAD_HEADER   = 3'd2,
      ST_BAD_CHECKSUM = 3'd3,
      ST_WRONG_DEST   = 3'd4,
      ST_TRUNCATED    = 3'd5
   } status_type;

   typedef struct packed {
      logic       last;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [31:0] source_ip;
      logic [7:0]  protocol;
      status_type  status;
      logic        packet_end;
      logic        payload_valid;
      logic [7:0]  payload_byte;
   } result_type;

endpackage

// File: rtl/ipv4rx_in_stage.sv
// Input register of the IPv4 receive header check unit.
// Holds one accepted item until the parser consumes it; uses ipv4rx_pkg.
`timescale 1ns / 1ps

module ipv4rx_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ipv4rx_pkg::item_type in_item,
   input  logic                consume,
   output logic                hold_valid,
   output ipv4rx_pkg::item_type hold_item
);
   import ipv4rx_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign in_ready   = !valid_ff || consume;
   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

// File: rtl/ipv4rx_parser.sv
// Header parser of the IPv4 receive header check unit: per-packet state, checksum,
// header checks and payload forwarding. Uses ipv4rx_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "ipv4_rx_header_check_unit_assert.svh"

module ipv4rx_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [31:0]           local_ip,
   input  logic                  step,
   input  ipv4rx_pkg::item_type  item,
   output logic                  has_result,
   output ipv4rx_pkg::result_type result
);
   import ipv4rx_pkg::*;

   logic [15:0] byte_count_ff, byte_count_in;
   logic [3:0]  header_words_ff, header_words_in;
   logic [15:0] total_length_ff, total_length_in;
   logic [15:0] sum_acc_ff, sum_acc_in;
   logic [15:0] stored_sum_ff, stored_sum_in;
   logic [7:0]  high_byte_hold_ff, high_byte_hold_in;
   logic [31:0] dest_addr_ff, dest_addr_in;
   logic [31:0] src_addr_ff, src_addr_in;
   logic [7:0]  proto_reg_ff, proto_reg_in;
   status_type  error_code_ff, error_code_in;

   logic [15:0] n;
   logic [7:0]  b;
   logic [5:0]  hb;
   logic [15:0] hb_wide;
   logic        in_header;
   logic [15:0] word;
   logic [16:0] sum_wide;
   logic        fwd;
   logic [16:0] count;
   status_type  st;

   always_comb begin
      n                 = byte_count_ff;
      b                 = item.data_byte;
      header_words_in   = header_words_ff;
      total_length_in   = total_length_ff;
      sum_acc_in        = sum_acc_ff;
      stored_sum_in     = stored_sum_ff;
      high_byte_hold_in = high_byte_hold_ff;
      dest_addr_in      = dest_addr_ff;
      src_addr_in       = src_addr_ff;
      proto_reg_in      = proto_reg_ff;
      error_code_in     = error_code_ff;
      fwd               = 1'b0;
      st                = ST_OK;

      if (n == 16'd0) begin
         header_words_in = b[3:0];
         if (b[7:4] != 4'd4 || b[3:0] < 4'd5) begin
            error_code_in = ST_BAD_HEADER;
         end
      end
      hb        = {header_words_in, 2'b00};
      hb_wide   = {10'd0, hb};
      in_header = n < hb_wide;
      word      = (n == 16'd11) ? 16'd0 : {high_byte_hold_ff, b};
      sum_wide  = {1'b0, sum_acc_ff} + {1'b0, word};

      if (in_header) begin
         if (!n[0]) begin
            high_byte_hold_in = b;
         end else begin
            sum_acc_in = sum_wide[15:0] + {15'd0, sum_wide[16]};
         end
         if (n == 16'd2 || n == 16'd3) begin
            total_length_in = {total_length_ff[7:0], b};
         end else if (n == 16'd9) begin
            proto_reg_in = b;
         end else if (n == 16'd10 || n == 16'd11) begin
            stored_sum_in = {stored_sum_ff[7:0], b};
         end else if (n inside {[16'd12:16'd15]}) begin
            src_addr_in = {src_addr_ff[23:0], b};
         end else if (n inside {[16'd16:16'd19]}) begin
            dest_addr_in = {dest_addr_ff[23:0], b};
         end

         if (n + 16'd1 == hb_wide && error_code_in == ST_OK) begin
            if (total_length_in < hb_wide) begin
               error_code_in = ST_BAD_HEADER;
            end else if (~sum_acc_in != stored_sum_in) begin
               error_code_in = ST_BAD_CHECKSUM;
            end else if (dest_addr_in != local_ip) begin
               error_code_in = ST_WRONG_DEST;
            end
         end
      end else if (hb >= 6'd20 && error_code_in == ST_OK && n < total_length_ff) begin
         fwd = 1'b1;
      end

      byte_count_in = (n != 16'hFFFF) ? n + 16'd1 : n;
      count         = {1'b0, n} + 17'd1;

      if (count < 17'd20) begin
         st = ST_TOO_SHORT;
      end else if (error_code_in == ST_BAD_HEADER) begin
         st = ST_BAD_HEADER;
      end else if (count < {11'd0, hb}) begin
         st = ST_TRUNCATED;
      end else if (error_code_in != ST_OK) begin
         st = error_code_in;
      end else if (count < {1'b0, total_length_in}) begin
         st = ST_TRUNCATED;
      end

      has_result           = fwd || item.last;
      result.payload_byte  = fwd ? b : 8'd0;
      result.payload_valid = fwd;
      result.packet_end    = item.last;
      result.status        = item.last ? st : ST_OK;
      result.protocol      = (item.last && st != ST_TOO_SHORT) ? proto_reg_in : 8'd0;
      result.source_ip     = (item.last && st != ST_TOO_SHORT) ? src_addr_in : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.last)) begin
         byte_count_ff     <= '0;
         header_words_ff   <= '0;
         total_length_ff   <= '0;
         sum_acc_ff        <= '0;
         stored_sum_ff     <= '0;
         high_byte_hold_ff <= '0;
         dest_addr_ff      <= '0;
         src_addr_ff       <= '0;
         proto_reg_ff      <= '0;
         error_code_ff     <= ST_OK;
      end else if (step) begin
         byte_count_ff     <= byte_count_in;
         header_words_ff   <= header_words_in;
         total_length_ff   <= total_length_in;
         sum_acc_ff        <= sum_acc_in;
         stored_sum_ff     <= stored_sum_in;
         high_byte_hold_ff <= high_byte_hold_in;
         dest_addr_ff      <= dest_addr_in;
         src_addr_ff       <= src_addr_in;
         proto_reg_ff      <= proto_reg_in;
         error_code_ff     <= error_code_in;
      end
   end

   `IPV4RX_ASSERT_NEXT(a_rearm_after_last, clock, reset, step && item.last,
      byte_count_ff == 16'd0, "byte count not cleared after the last item")
   `IPV4RX_ASSERT_NEXT(a_count_no_wrap, clock, reset, step && !item.last,
      byte_count_ff != 16'd0, "byte count wrapped within a packet")
   `IPV4RX_ASSERT_SAME(a_fwd_only_clean, clock, reset, step && fwd,
      error_code_ff == ST_OK && header_words_ff >= 4'd5, "payload forwarded after a failed header")

endmodule

// File: rtl/ipv4rx_out_stage.sv
// Result register of the IPv4 receive header check unit.
// Holds one result item until the downstream side takes it; uses ipv4rx_pkg.
`timescale 1ns / 1ps

module ipv4rx_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  ipv4rx_pkg::result_type  load_result,
   output logic                    can_take,
   output logic                    out_valid,
   input  logic                    out_ready,
   output ipv4rx_pkg::result_type  out_result
);
   import ipv4rx_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign can_take   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= load_result;
      end
   end

endmodule

// File: rtl/ipv4_rx_header_check_unit.sv
// Top level of the IPv4 receive header check unit.
// Instantiates ipv4rx_in_stage, ipv4rx_parser and ipv4rx_out_stage; uses ipv4rx_pkg.
//
// The unit takes a received IPv4 packet one byte per item, checks version, header
// length, header checksum, destination address against the local address and total
// length, forwards the payload bytes up to the total length and reports a status with
// the protocol and source address on the packet's last byte. It accepts one item in
// every clock cycle unless the result register stalls; a result item is presented
// once its byte, caught in the input register, has gone through the single parser
// pass into the result register. A stalled result register holds back the input only
// once both registers are full.
`timescale 1ns / 1ps

module ipv4_rx_header_check_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [31:0]                         csr_wr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ipv4rx_pkg::TDATA_IN_W-1:0]   req_tdata,   // data_byte[7:0]
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ipv4rx_pkg::TDATA_OUT_W-1:0]  rsp_tdata,   // payload_byte[7:0], status[10:8],
                                                            // protocol[18:11], source_ip[50:19]
   output logic                                rsp_tuser,   // payload_valid
   output logic                                rsp_tlast
);
   import ipv4rx_pkg::*;

   logic [31:0] local_ip_ff;
   item_type    req_item;
   item_type    hold_item;
   logic        hold_valid;
   logic        can_take;
   logic        advance;
   logic        has_result;
   result_type  step_result;
   result_type  rsp_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff <= '0;
      end else if (csr_wr_en) begin
         local_ip_ff <= csr_wr_data;
      end
   end

   assign req_item.data_byte = req_tdata[7:0];
   assign req_item.last      = req_tlast;
   assign advance            = hold_valid && can_take;

   ipv4rx_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .consume    (advance),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   ipv4rx_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .local_ip   (local_ip_ff),
      .step       (advance),
      .item       (hold_item),
      .has_result (has_result),
      .result     (step_result)
   );

   ipv4rx_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (advance && has_result),
      .load_result (step_result),
      .can_take    (can_take),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (rsp_result)
   );

   assign rsp_tdata = {5'd0, rsp_result.source_ip, rsp_result.protocol,
                       3'(rsp_result.status), rsp_result.payload_byte};
   assign rsp_tuser = rsp_result.payload_valid;
   assign rsp_tlast = rsp_result.packet_end;

endmodule

// File: tb/ipv4rx_header_checker.sv
// Checker for the IPv4 receive header check unit: watches the register port and both
// item channels, predicts every result item and compares it field by field.
// Depends on ipv4rx_pkg for the status codes and the result item type.
`timescale 1ns / 1ps

module ipv4rx_header_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [31:0]                        csr_wr_data,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [ipv4rx_pkg::TDATA_IN_W-1:0]  req_tdata,
   input  logic                               req_tlast,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [ipv4rx_pkg::TDATA_OUT_W-1:0] rsp_tdata,
   input  logic                               rsp_tuser,
   input  logic                               rsp_tlast,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 results_seen
);
   import ipv4rx_pkg::*;

   logic [31:0] local_addr;
   logic [15:0] byte_index;
   logic [3:0]  ihl_words;
   logic [15:0] length_field;
   logic [15:0] csum_acc;
   logic [15:0] csum_field;
   logic [7:0]  even_byte;
   logic [31:0] dst_ip;
   logic [31:0] src_ip;
   logic [7:0]  proto_id;
   status_type  header_fault;

   result_type  results_due [$];

   task automatic clear_packet_state();
      byte_index   = '0;
      ihl_words    = '0;
      length_field = '0;
      csum_acc     = '0;
      csum_field   = '0;
      even_byte    = '0;
      dst_ip       = '0;
      src_ip       = '0;
      proto_id     = '0;
      header_fault = ST_OK;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] wanted);
      $display("[%0t] result item %0d: %s is %0h, expected %0h",
               $realtime, results_seen, what, got, wanted);
      fail_count++;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic is_last);
      int          n;
      int          hb;
      int          count;
      logic [16:0] s;
      logic [15:0] word;
      logic        fwd;
      result_type  r;
      status_type  st;
      n   = int'(byte_index);
      fwd = 1'b0;
      if (n == 0) begin
         ihl_words = b[3:0];
         if (b[7:4] != 4'd4 || b[3:0] < 4'd5)
            header_fault = ST_BAD_HEADER;
      end
      hb = int'(ihl_words) * 4;
      if (n < hb) begin
         if (n % 2 == 0) begin
            even_byte = b;
         end else begin
            word     = (n == 11) ? 16'h0000 : {even_byte, b};
            s        = {1'b0, csum_acc} + {1'b0, word};
            csum_acc = s[15:0] + {15'd0, s[16]};
         end
         if (n == 2 || n == 3)
            length_field = {length_field[7:0], b};
         else if (n == 9)
            proto_id = b;
         else if (n == 10 || n == 11)
            csum_field = {csum_field[7:0], b};
         else if (n >= 12 && n <= 15)
            src_ip = {src_ip[23:0], b};
         else if (n >= 16 && n <= 19)
            dst_ip = {dst_ip[23:0], b};
         if (n + 1 == hb && header_fault == ST_OK) begin
            if (int'(length_field) < hb)
               header_fault = ST_BAD_HEADER;
            else if (~csum_acc != csum_field)
               header_fault = ST_BAD_CHECKSUM;
            else if (dst_ip != local_addr)
               header_fault = ST_WRONG_DEST;
         end
      end else if (hb >= 20 && header_fault == ST_OK && n < int'(length_field)) begin
         fwd = 1'b1;
      end
      if (byte_index != 16'hFFFF)
         byte_index = byte_index + 16'd1;
      if (fwd || is_last) begin
         r.payload_byte  = fwd ? b : 8'h00;
         r.payload_valid = fwd;
         r.packet_end    = is_last;
         r.status        = ST_OK;
         r.protocol      = '0;
         r.source_ip     = '0;
         if (is_last) begin
            count = n + 1;
            if (count < 20)
               st = ST_TOO_SHORT;
            else if (header_fault == ST_BAD_HEADER)
               st = ST_BAD_HEADER;
            else if (count < hb)
               st = ST_TRUNCATED;
            else if (header_fault != ST_OK)
               st = header_fault;
            else if (count < int'(length_field))
               st = ST_TRUNCATED;
            else
               st = ST_OK;
            r.status = st;
            if (st != ST_TOO_SHORT) begin
               r.protocol  = proto_id;
               r.source_ip = src_ip;
            end
            clear_packet_state();
         end
         results_due.push_back(r);
      end
   endtask

   task automatic check_result();
      result_type want;
      if (results_due.size() == 0) begin
         report_mismatch("unexpected item, tdata low word", rsp_tdata[31:0], 32'h0);
         return;
      end
      want = results_due.pop_front();
      if (rsp_tdata[7:0] != want.payload_byte)
         report_mismatch("payload_byte", 32'(rsp_tdata[7:0]), 32'(want.payload_byte));
      if (rsp_tdata[10:8] != want.status)
         report_mismatch("status", 32'(rsp_tdata[10:8]), 32'(want.status));
      if (rsp_tdata[18:11] != want.protocol)
         report_mismatch("protocol", 32'(rsp_tdata[18:11]), 32'(want.protocol));
      if (rsp_tdata[50:19] != want.source_ip)
         report_mismatch("source_ip", rsp_tdata[50:19], want.source_ip);
      if (rsp_tdata[TDATA_OUT_W-1:51] != '0)
         report_mismatch("tdata padding", 32'(rsp_tdata[TDATA_OUT_W-1:51]), 32'h0);
      if (rsp_tuser != want.payload_valid)
         report_mismatch("payload_valid", 32'(rsp_tuser), 32'(want.payload_valid));
      if (rsp_tlast != want.packet_end)
         report_mismatch("packet_end", 32'(rsp_tlast), 32'(want.packet_end));
      results_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_packet_state();
         local_addr = '0;
         results_due.delete();
      end else begin
         if (csr_wr_en)
            local_addr = csr_wr_data;
         if (rsp_tvalid && rsp_tready)
            check_result();
         if (req_tvalid && req_tready)
            parse_byte(req_tdata[7:0], req_tlast);
      end
      pending = results_due.size();
   end

endmodule

// File: tb/ipv4_rx_header_check_unit_test.sv
// Top of the testbench for the IPv4 receive header check unit: builds IPv4 packets,
// good and faulty, drives them with random gaps and stalls, and gives the verdict.
// Depends on ipv4rx_pkg, the unit itself and ipv4rx_header_checker.
`timescale 1ns / 1ps

module ipv4_rx_header_check_unit_test;
   import ipv4rx_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   typedef enum int {
      PK_GOOD,
      PK_BAD_VERSION,
      PK_BAD_IHL,
      PK_SHORT_TOTAL,
      PK_BAD_CHECKSUM,
      PK_WRONG_DEST,
      PK_TRUNC_HEADER,
      PK_TRUNC_PAYLOAD,
      PK_TOO_SHORT,
      PK_ZERO_SUM_GOOD,
      PK_ZERO_SUM_ALT,
      PK_NOISE
   } packet_kind_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [31:0]            csr_wr_data;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [TDATA_IN_W-1:0]  req_tdata;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [TDATA_OUT_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   int          fail_count;
   int          pending;
   int          results_seen;
   int          cycles;
   int          bytes_sent;
   int          packets_sent;
   logic        idling;
   logic [31:0] local_addr;
   logic [7:0]  hdr [0:59];
   logic [7:0]  pkt_bytes [$];

   ipv4_rx_header_check_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   ipv4rx_header_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .fail_count   (fail_count),
      .pending      (pending),
      .results_seen (results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Run stopped at the cycle limit with %0d result items outstanding.", pending);
      $display("** ipv4_rx_header_check_unit: FAILED **");
      $finish;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (idling && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [15:0] header_sum(input int hb);
      logic [31:0] acc;
      acc = 32'd0;
      for (int i = 0; i < hb; i += 2)
         if (i != 10)
            acc += {16'd0, hdr[i], hdr[i + 1]};
      while (acc[31:16] != 16'd0)
         acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
      return acc[15:0];
   endfunction

   task automatic build_packet(input packet_kind_type kind, input int ihl, input int pay_len,
                               input int pad_len);
      logic [3:0]  ver;
      logic [3:0]  ihl_field;
      logic [15:0] length_field;
      logic [15:0] sum;
      logic [15:0] cks;
      logic [15:0] flip;
      logic [31:0] dest;
      logic [31:0] mask;
      int          hb;
      int          tot;
      int          n_send;
      pkt_bytes.delete();
      if (kind == PK_NOISE) begin
         n_send = $urandom_range(1, 40);
         for (int i = 0; i < n_send; i++)
            pkt_bytes.push_back(8'($urandom));
         if ($urandom_range(0, 1) == 1)
            pkt_bytes[0] = 8'h45;
         return;
      end
      if (kind == PK_TRUNC_HEADER && ihl < 6)
         ihl = $urandom_range(6, 15);
      if (kind == PK_TRUNC_PAYLOAD && pay_len < 1)
         pay_len = $urandom_range(1, 16);
      hb  = ((kind == PK_BAD_IHL) ? 5 : ihl) * 4;
      tot = hb + pay_len;
      for (int i = 0; i < 60; i++)
         hdr[i] = 8'($urandom);
      ver       = 4'd4;
      ihl_field = ihl[3:0];
      if (kind == PK_BAD_VERSION) begin
         ver = 4'($urandom_range(0, 14));
         if (ver >= 4'd4)
            ver = ver + 4'd1;
      end
      if (kind == PK_BAD_IHL)
         ihl_field = (ihl < 5) ? ihl[3:0] : 4'($urandom_range(0, 4));
      hdr[0]       = {ver, ihl_field};
      length_field = (kind == PK_SHORT_TOTAL) ? 16'($urandom_range(0, hb - 1)) : tot[15:0];
      hdr[2]       = length_field[15:8];
      hdr[3]       = length_field[7:0];
      dest         = local_addr;
      if (kind == PK_WRONG_DEST) begin
         mask = $urandom;
         if (mask == 32'd0)
            mask = 32'd1;
         dest = local_addr ^ mask;
      end
      {hdr[16], hdr[17], hdr[18], hdr[19]} = dest;
      hdr[10] = 8'h00;
      hdr[11] = 8'h00;
      if (kind == PK_ZERO_SUM_GOOD || kind == PK_ZERO_SUM_ALT) begin
         hdr[4] = 8'h00;
         hdr[5] = 8'h00;
         sum    = ~header_sum(hb);
         hdr[4] = sum[15:8];
         hdr[5] = sum[7:0];
      end
      cks = ~header_sum(hb);
      if (kind == PK_ZERO_SUM_ALT)
         cks = 16'hFFFF;
      if (kind == PK_BAD_CHECKSUM) begin
         flip = 16'($urandom);
         if (flip == 16'd0)
            flip = 16'd1;
         cks = cks ^ flip;
      end
      hdr[10] = cks[15:8];
      hdr[11] = cks[7:0];
      case (kind)
         PK_TRUNC_HEADER:  n_send = $urandom_range(20, hb - 1);
         PK_TRUNC_PAYLOAD: n_send = $urandom_range(hb, tot - 1);
         PK_TOO_SHORT:     n_send = (pay_len >= 1 && pay_len <= 19) ? pay_len
                                                                    : $urandom_range(1, 19);
         default:          n_send = tot + pad_len;
      endcase
      for (int i = 0; i < n_send; i++)
         pkt_bytes.push_back((i < hb) ? hdr[i] : 8'($urandom));
   endtask

   task automatic send_item(input logic [7:0] b, input logic is_last);
      if (idling && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_packet(input packet_kind_type kind, input int ihl, input int pay_len,
                              input int pad_len);
      build_packet(kind, ihl, pay_len, pad_len);
      for (int i = 0; i < pkt_bytes.size(); i++)
         send_item(pkt_bytes[i], i == pkt_bytes.size() - 1);
      bytes_sent += pkt_bytes.size();
      packets_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_local_ip(input logic [31:0] addr);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= addr;
      @(negedge clock);
      csr_wr_en  <= 1'b0;
      local_addr  = addr;
   endtask

   task automatic random_traffic(input int n_bytes);
      int              start;
      int              r;
      int              ihl;
      int              pay;
      int              pad;
      packet_kind_type kind;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         r   = $urandom_range(0, 99);
         ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
         pay = $urandom_range(0, 24);
         pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
         if (r < 60)
            kind = PK_GOOD;
         else if (r < 90)
            kind = packet_kind_type'($urandom_range(PK_BAD_VERSION, PK_ZERO_SUM_ALT));
         else
            kind = PK_NOISE;
         send_packet(kind, ihl, pay, pad);
      end
   endtask

   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 32'd0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      idling       = 1'b1;
      local_addr   = 32'd0;
      bytes_sent   = 0;
      packets_sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_local_ip($urandom);
      send_packet(PK_GOOD, 5, 0, 0);
      send_packet(PK_GOOD, 15, 1, 0);
      send_packet(PK_GOOD, 5, 8, 3);
      send_packet(PK_BAD_VERSION, 5, 4, 0);
      send_packet(PK_BAD_IHL, 0, 4, 0);
      send_packet(PK_BAD_IHL, 4, 4, 0);
      send_packet(PK_SHORT_TOTAL, 5, 4, 0);
      send_packet(PK_BAD_CHECKSUM, 5, 4, 0);
      send_packet(PK_WRONG_DEST, 5, 4, 0);
      send_packet(PK_TRUNC_HEADER, 8, 4, 0);
      send_packet(PK_TRUNC_PAYLOAD, 5, 10, 0);
      send_packet(PK_TOO_SHORT, 5, 1, 0);
      send_packet(PK_TOO_SHORT, 5, 19, 0);
      send_packet(PK_ZERO_SUM_GOOD, 5, 6, 0);
      send_packet(PK_ZERO_SUM_ALT, 5, 6, 0);
      send_packet(PK_NOISE, 5, 0, 0);

      write_local_ip(32'hFFFF_FFFF);
      send_packet(PK_GOOD, 6, 5, 0);
      send_packet(PK_WRONG_DEST, 5, 3, 0);

      write_local_ip(32'h0000_0000);
      random_traffic(250);
      write_local_ip($urandom);
      random_traffic(250);
      write_local_ip($urandom);
      idling = 1'b0;
      random_traffic(250);

      wait_drained();
      $display("Sent %0d packets (%0d bytes) under five local addresses, good and faulty,",
               packets_sent, bytes_sent);
      $display("with random gaps and stalls; %0d result items checked.", results_seen);
      if (fail_count == 0 && pending == 0)
         $display("** ipv4_rx_header_check_unit: PASSED **");
      else
         $display("** ipv4_rx_header_check_unit: FAILED **");
      $finish;
   end

endmodule

// File: ipv4_rx_header_check_unit.f
+incdir+rtl
rtl/ipv4rx_pkg.sv
rtl/ipv4rx_in_stage.sv
rtl/ipv4rx_parser.sv
rtl/ipv4rx_out_stage.sv
rtl/ipv4_rx_header_check_unit.sv
tb/ipv4rx_header_checker.sv
tb/ipv4_rx_header_check_unit_test.sv
